// ===== rtl/calsec_pkg.sv =====
`timescale 1ns / 1ps

package calsec_pkg;

    localparam int ACTION_W    = 2;
    localparam int LOAD_YEAR_W = 12;
    localparam int YEAR_W      = 8;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int SECOND_W    = 6;
    localparam int DELAY_W     = 24;
    localparam int SEED_W      = 32;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INC  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEC  = 2'd2;

    localparam logic [LOAD_YEAR_W-1:0] YEAR_BASE = 12'd2000;

    localparam logic [YEAR_W-1:0]   YEAR_TOP     = 8'd99;
    // offsets of the years 2100 and 1900, which are not leap years
    localparam logic [YEAR_W-1:0]   YEAR_2100    = 8'd100;
    localparam logic [YEAR_W-1:0]   YEAR_1900    = 8'h9C;
    localparam logic [SECOND_W-1:0] SECOND_WRAP  = 6'd60;
    localparam logic [SECOND_W-1:0] SECOND_LAST  = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_WRAP  = 6'd60;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_WRAP    = 5'd24;
    localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_WRAP   = 4'd13;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_APR    = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_JUN    = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_SEP    = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_NOV    = 4'd11;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } cal_time_t;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [LOAD_YEAR_W-1:0] load_year;
        logic [MONTH_W-1:0]     load_month;
        logic [DAY_W-1:0]       load_day;
        logic [HOUR_W-1:0]      load_hour;
        logic [MINUTE_W-1:0]    load_minute;
        logic [SECOND_W-1:0]    load_second;
    } cal_item_t;

    localparam cal_time_t TIME_RESET = '{
        year: '0, month: MONTH_FIRST, day: DAY_FIRST, hour: '0, minute: '0, second: '0
    };

    // Gregorian rule over 1872..2127: only 1900 and 2100 break the rule of four
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic [YEAR_W-1:0]  year);
        logic leap;
        logic [DAY_W-1:0] len;
        leap = (year[1:0] == 2'b00) && (year != YEAR_2100) && (year != YEAR_1900);
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/calsec_if.sv =====
`timescale 1ns / 1ps

interface calsec_in_if;
    logic                                valid;
    logic                                ready;
    logic [calsec_pkg::ACTION_W-1:0]     action;
    logic [calsec_pkg::LOAD_YEAR_W-1:0]  load_year;
    logic [calsec_pkg::MONTH_W-1:0]      load_month;
    logic [calsec_pkg::DAY_W-1:0]        load_day;
    logic [calsec_pkg::HOUR_W-1:0]       load_hour;
    logic [calsec_pkg::MINUTE_W-1:0]     load_minute;
    logic [calsec_pkg::SECOND_W-1:0]     load_second;

    modport source (
        output valid, action, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        input  ready
    );
    modport sink (
        input  valid, action, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        output ready
    );
endinterface

interface calsec_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [calsec_pkg::YEAR_W-1:0] out_year;
    logic [calsec_pkg::MONTH_W-1:0]     out_month;
    logic [calsec_pkg::DAY_W-1:0]       out_day;
    logic [calsec_pkg::HOUR_W-1:0]      out_hour;
    logic [calsec_pkg::MINUTE_W-1:0]    out_minute;
    logic [calsec_pkg::SECOND_W-1:0]    out_second;
    logic                               in_bounds;
    logic [calsec_pkg::SEED_W-1:0]      seed;

    modport source (
        output valid, out_year, out_month, out_day, out_hour, out_minute,
               out_second, in_bounds, seed,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_day, out_hour, out_minute,
               out_second, in_bounds, seed,
        output ready
    );
endinterface

// ===== rtl/calsec_step.sv =====
`timescale 1ns / 1ps

module calsec_step (
    input  calsec_pkg::cal_time_t cur,
    input  calsec_pkg::cal_item_t item,
    output calsec_pkg::cal_time_t nxt
);
    import calsec_pkg::*;

    logic [SECOND_W-1:0]    sec_inc, sec_dec;
    logic [MINUTE_W-1:0]    min_inc, min_dec;
    logic [HOUR_W-1:0]      hour_inc, hour_dec;
    logic [DAY_W-1:0]       day_inc, day_dec;
    logic [MONTH_W-1:0]     mon_inc, mon_dec;
    logic [YEAR_W-1:0]      year_inc, year_dec;
    logic                   c_sec, c_min, c_hour, c_day, c_mon;
    logic                   b_sec, b_min, b_hour, b_day, b_mon;
    logic [LOAD_YEAR_W-1:0] year_off;
    cal_time_t              up, down, loaded;

    assign sec_inc  = cur.second + 1'b1;
    assign min_inc  = cur.minute + 1'b1;
    assign hour_inc = cur.hour + 1'b1;
    assign day_inc  = cur.day + 1'b1;
    assign mon_inc  = cur.month + 1'b1;
    assign year_inc = cur.year + 1'b1;
    assign sec_dec  = cur.second - 1'b1;
    assign min_dec  = cur.minute - 1'b1;
    assign hour_dec = cur.hour - 1'b1;
    assign day_dec  = cur.day - 1'b1;
    assign mon_dec  = cur.month - 1'b1;
    assign year_dec = cur.year - 1'b1;

    // carry chain: month length taken from the month being left
    assign c_sec  = (sec_inc == SECOND_WRAP);
    assign c_min  = c_sec  && (min_inc == MINUTE_WRAP);
    assign c_hour = c_min  && (hour_inc == HOUR_WRAP);
    assign c_day  = c_hour && (day_inc > month_len(cur.month, cur.year));
    assign c_mon  = c_day  && (mon_inc == MONTH_WRAP);

    always_comb
    begin
        up.second = c_sec  ? '0 : sec_inc;
        up.minute = c_min  ? '0 : (c_sec ? min_inc : cur.minute);
        up.hour   = c_hour ? '0 : (c_min ? hour_inc : cur.hour);
        up.day    = c_day  ? DAY_FIRST : (c_hour ? day_inc : cur.day);
        up.month  = c_mon  ? MONTH_FIRST : (c_day ? mon_inc : cur.month);
        up.year   = c_mon  ? year_inc : cur.year;
    end

    // borrow chain: month length taken from the month entered
    assign b_sec  = (cur.second == '0);
    assign b_min  = b_sec  && (cur.minute == '0);
    assign b_hour = b_min  && (cur.hour == '0);
    assign b_day  = b_hour && (cur.day == DAY_FIRST);
    assign b_mon  = b_day  && (cur.month == MONTH_FIRST);

    always_comb
    begin
        down.second = b_sec  ? SECOND_LAST : sec_dec;
        down.minute = b_min  ? MINUTE_LAST : (b_sec ? min_dec : cur.minute);
        down.hour   = b_hour ? HOUR_LAST : (b_min ? hour_dec : cur.hour);
        down.month  = b_mon  ? MONTH_LAST : (b_day ? mon_dec : cur.month);
        down.year   = b_mon  ? year_dec : cur.year;
        down.day    = b_day  ? month_len(down.month, down.year)
                             : (b_hour ? day_dec : cur.day);
    end

    assign year_off = item.load_year - YEAR_BASE;

    always_comb
    begin
        loaded.year   = year_off[YEAR_W-1:0];
        loaded.month  = item.load_month;
        loaded.day    = item.load_day;
        loaded.hour   = item.load_hour;
        loaded.minute = item.load_minute;
        loaded.second = item.load_second;
    end

    always_comb
    begin
        case (item.action)
            ACT_LOAD: nxt = loaded;
            ACT_INC:  nxt = up;
            ACT_DEC:  nxt = down;
            default:  nxt = cur;
        endcase
    end

endmodule

// ===== rtl/calendar_second_up_down_counter.sv =====
`timescale 1ns / 1ps

// Calendar clock with one-second up and down steps. Each input beat loads a
// date and time, steps one second forward or back (carrying or borrowing
// through the calendar, leap years included), or with the spare action code
// leaves the time alone; every beat gives exactly one result beat with the
// time after the update, an in-range flag for years 2000..2099 and a 32-bit
// seed. A beat is taken into an input register and then passes through the
// step logic into the result register; one beat per cycle is sustained
// while the result side does not stall; the time registers loop through
// the step logic. The user must write seed_delay through the configuration
// port only while no beat is in flight; the block does not enforce this.
module calendar_second_up_down_counter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [calsec_pkg::DELAY_W-1:0]   cfg_wr_data,
    calsec_in_if.sink                        in_ch,
    calsec_out_if.source                     out_ch
);
    import calsec_pkg::*;

    logic                 item_valid_reg;
    cal_item_t            item_reg;
    cal_time_t            time_reg, time_next;
    logic [DELAY_W-1:0]   delay_reg;
    logic                 out_valid_reg;
    cal_time_t            res_time_reg;
    logic                 res_bounds_reg, res_bounds_next;
    logic [SEED_W-1:0]    res_seed_reg, res_seed_next;
    logic                 advance;
    logic [8:0]           prod;
    logic [7:0]           seed_top;

    assign advance      = item_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= '0;
        else if (cfg_wr_en)
            delay_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ch.ready)
            item_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.action      <= in_ch.action;
            item_reg.load_year   <= in_ch.load_year;
            item_reg.load_month  <= in_ch.load_month;
            item_reg.load_day    <= in_ch.load_day;
            item_reg.load_hour   <= in_ch.load_hour;
            item_reg.load_minute <= in_ch.load_minute;
            item_reg.load_second <= in_ch.load_second;
        end
    end

    calsec_step u_step (
        .cur  (time_reg),
        .item (item_reg),
        .nxt  (time_next)
    );

    // only the low byte of the top term survives the shift by 24
    assign prod     = {5'd0, time_next.month} * {4'd0, time_next.day};
    assign seed_top = prod[7:0] + {2'b00, time_next.minute} + {2'b00, time_next.second};
    assign res_seed_next = {8'd0, delay_reg}
                         + {{(SEED_W-YEAR_W){time_next.year[YEAR_W-1]}}, time_next.year}
                         + {seed_top, 24'd0}
                         + {11'd0, time_next.hour, 16'd0};
    assign res_bounds_next = !time_next.year[YEAR_W-1] && (time_next.year <= YEAR_TOP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= TIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                time_reg <= time_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_time_reg   <= time_next;
            res_bounds_reg <= res_bounds_next;
            res_seed_reg   <= res_seed_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_year   = res_time_reg.year;
    assign out_ch.out_month  = res_time_reg.month;
    assign out_ch.out_day    = res_time_reg.day;
    assign out_ch.out_hour   = res_time_reg.hour;
    assign out_ch.out_minute = res_time_reg.minute;
    assign out_ch.out_second = res_time_reg.second;
    assign out_ch.in_bounds  = res_bounds_reg;
    assign out_ch.seed       = res_seed_reg;

    // a held input beat must not be dropped or overwritten
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("input beat lost while stalled");

    // each processed beat leaves a result behind
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && (res_time_reg == time_reg))
        else $error("result does not match updated time");

    // a plain forward step inside the minute only bumps the second
    a_inc_second: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.action == ACT_INC) && (time_reg.second < SECOND_LAST)
        |=> (time_reg.second == $past(time_reg.second) + 1'b1)
            && (time_reg.minute == $past(time_reg.minute)))
        else $error("forward step went wrong");

    // the time changes only when a beat is processed
    a_time_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(time_reg))
        else $error("time changed without a beat");

    a_bounds_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_bounds_reg
            == (!res_time_reg.year[YEAR_W-1] && (res_time_reg.year <= YEAR_TOP)))
        else $error("range flag disagrees with year");

endmodule

// ===== test/calsec_time_checker.sv =====
`timescale 1ns / 1ps

module calsec_time_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [calsec_pkg::DELAY_W-1:0] cfg_wr_data,
    calsec_in_if                           in_mon,
    calsec_out_if                          out_mon,
    output int                             fail_count,
    output int                             outstanding
);

    import calsec_pkg::*;

    typedef struct packed {
        cal_time_t         now;
        logic              in_bounds;
        logic [SEED_W-1:0] seed;
    } cal_report_t;

    cal_time_t          clock_now  = TIME_RESET;
    logic [DELAY_W-1:0] seed_delay = '0;
    cal_report_t        expected_reports[$];
    int                 mismatches = 0;
    int                 backlog    = 0;

    assign fail_count  = mismatches;
    assign outstanding = backlog;

    // full Gregorian rule on the real year; months 0 and 13..15 count as 31 days
    function automatic int days_in_month(input logic [MONTH_W-1:0] month,
                                         input logic [YEAR_W-1:0]  year);
        int full_year;
        bit leap;
        full_year = $signed(year);
        full_year = full_year + int'(YEAR_BASE);
        leap = ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
        case (month)
            MONTH_FEB: return leap ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic cal_time_t tick_forward(input cal_time_t t);
        cal_time_t n;
        n = t;
        n.second = t.second + 1'b1;
        if (n.second != SECOND_WRAP) return n;
        n.second = '0;
        n.minute = t.minute + 1'b1;
        if (n.minute != MINUTE_WRAP) return n;
        n.minute = '0;
        n.hour = t.hour + 1'b1;
        if (n.hour != HOUR_WRAP) return n;
        n.hour = '0;
        // a day field that wraps to zero never carries
        n.day = t.day + 1'b1;
        if (n.day > days_in_month(n.month, n.year))
        begin
            n.day   = DAY_FIRST;
            n.month = t.month + 1'b1;
            if (n.month == MONTH_WRAP)
            begin
                n.month = MONTH_FIRST;
                n.year  = t.year + 1'b1;
            end
        end
        return n;
    endfunction

    function automatic cal_time_t tick_back(input cal_time_t t);
        cal_time_t n;
        n = t;
        if (t.second != '0)
        begin
            n.second = t.second - 1'b1;
            return n;
        end
        n.second = SECOND_LAST;
        if (t.minute != '0)
        begin
            n.minute = t.minute - 1'b1;
            return n;
        end
        n.minute = MINUTE_LAST;
        if (t.hour != '0)
        begin
            n.hour = t.hour - 1'b1;
            return n;
        end
        n.hour = HOUR_LAST;
        if (t.day != DAY_FIRST)
        begin
            n.day = t.day - 1'b1;
            return n;
        end
        if (t.month == MONTH_FIRST)
        begin
            n.month = MONTH_LAST;
            n.year  = t.year - 1'b1;
        end
        else
            n.month = t.month - 1'b1;
        // length taken from the new month and year
        n.day = DAY_W'(days_in_month(n.month, n.year));
        return n;
    endfunction

    function automatic cal_time_t apply_item(input cal_time_t t, input cal_item_t it);
        cal_time_t n;
        logic [LOAD_YEAR_W-1:0] offset;
        n = t;
        case (it.action)
            ACT_LOAD:
            begin
                offset   = it.load_year - YEAR_BASE;
                n.year   = offset[YEAR_W-1:0];
                n.month  = it.load_month;
                n.day    = it.load_day;
                n.hour   = it.load_hour;
                n.minute = it.load_minute;
                n.second = it.load_second;
            end
            ACT_INC: n = tick_forward(t);
            ACT_DEC: n = tick_back(t);
            default: n = t;
        endcase
        return n;
    endfunction

    function automatic cal_report_t report_of(input cal_time_t t,
                                              input logic [DELAY_W-1:0] delay);
        cal_report_t r;
        logic [SEED_W-1:0] mix;
        r.now       = t;
        r.in_bounds = !t.year[YEAR_W-1] && (t.year <= YEAR_TOP);
        mix = SEED_W'(t.month) * SEED_W'(t.day) + SEED_W'(t.minute) + SEED_W'(t.second);
        r.seed = SEED_W'(delay) + {{(SEED_W-YEAR_W){t.year[YEAR_W-1]}}, t.year}
               + (mix << 24) + (SEED_W'(t.hour) << 16);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [SEED_W-1:0] want,
                               input logic [SEED_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        cal_item_t   item;
        cal_report_t want;
        if (!rst_n)
        begin
            clock_now  = TIME_RESET;
            seed_delay = '0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_wr_en)
                seed_delay = cfg_wr_data;
            // retire results before taking the new beat
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, expected none, got seed %0d",
                             $time, out_mon.seed);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("out_year", want.now.year, $unsigned(out_mon.out_year));
                    check_field("out_month", want.now.month, out_mon.out_month);
                    check_field("out_day", want.now.day, out_mon.out_day);
                    check_field("out_hour", want.now.hour, out_mon.out_hour);
                    check_field("out_minute", want.now.minute, out_mon.out_minute);
                    check_field("out_second", want.now.second, out_mon.out_second);
                    check_field("in_bounds", want.in_bounds, out_mon.in_bounds);
                    check_field("seed", want.seed, out_mon.seed);
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                item.action      = in_mon.action;
                item.load_year   = in_mon.load_year;
                item.load_month  = in_mon.load_month;
                item.load_day    = in_mon.load_day;
                item.load_hour   = in_mon.load_hour;
                item.load_minute = in_mon.load_minute;
                item.load_second = in_mon.load_second;
                clock_now = apply_item(clock_now, item);
                expected_reports.push_back(report_of(clock_now, seed_delay));
            end
        end
        backlog = expected_reports.size();
    end

endmodule

// ===== test/calendar_second_up_down_counter_tb.sv =====
`timescale 1ns / 1ps

module calendar_second_up_down_counter_tb;

    import calsec_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd3;
    localparam int PHASE_BEATS = 200;
    localparam int RX_HOLD     = 64;
    localparam int STALL_LIMIT = 1000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [DELAY_W-1:0] cfg_wr_data = '0;

    int tx_idle_pct  = 34;
    int rx_idle_pct  = 34;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int fail_count;
    int outstanding;

    calsec_in_if  in_ch ();
    calsec_out_if out_ch ();

    calendar_second_up_down_counter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    calsec_time_checker i_time_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // result side: random back-pressure, or a counted hold-off when asked
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int month_span(input int month, input int year);
        bit leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        case (month)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic cal_item_t mk_item(input logic [ACTION_W-1:0] act, input int y,
                                          input int mo, input int d, input int h,
                                          input int mi, input int s);
        cal_item_t it;
        it.action      = act;
        it.load_year   = y[LOAD_YEAR_W-1:0];
        it.load_month  = mo[MONTH_W-1:0];
        it.load_day    = d[DAY_W-1:0];
        it.load_hour   = h[HOUR_W-1:0];
        it.load_minute = mi[MINUTE_W-1:0];
        it.load_second = s[SECOND_W-1:0];
        return it;
    endfunction

    // load fields carry junk on non-load beats; they must be ignored
    function automatic cal_item_t step_item(input logic [ACTION_W-1:0] act);
        return mk_item(act, $urandom_range(4095), $urandom_range(15), $urandom_range(31),
                       $urandom_range(31), $urandom_range(63), $urandom_range(63));
    endfunction

    function automatic cal_item_t noise_item();
        return step_item(ACTION_W'($urandom_range(3)));
    endfunction

    // valid date, pulled towards the edges where carries and borrows run deep
    function automatic cal_item_t edge_date();
        int picks[8];
        int yr, mo, len, d, h, mi, s;
        picks = '{1872, 1900, 1999, 2000, 2024, 2099, 2100, 2127};
        yr = $urandom_range(1) ? picks[$urandom_range(7)] : $urandom_range(1872, 2127);
        case ($urandom_range(3))
            0: mo = 1;
            1: mo = 2;
            2: mo = 12;
            default: mo = $urandom_range(1, 12);
        endcase
        len = month_span(mo, yr);
        case ($urandom_range(3))
            0: d = 1;
            1: d = len;
            2: d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        if ($urandom_range(99) < 60)
        begin
            if ($urandom_range(1))
            begin
                h  = 23;
                mi = 59;
                s  = $urandom_range(52, 59);
            end
            else
            begin
                h  = 0;
                mi = 0;
                s  = $urandom_range(0, 7);
            end
        end
        else
        begin
            h  = $urandom_range(1) ? ($urandom_range(1) ? 0 : 23) : $urandom_range(23);
            mi = $urandom_range(1) ? ($urandom_range(1) ? 0 : 59) : $urandom_range(59);
            s  = $urandom_range(59);
        end
        return mk_item(ACT_LOAD, yr, mo, d, h, mi, s);
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input cal_item_t it);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= it.action;
        in_ch.load_year   <= it.load_year;
        in_ch.load_month  <= it.load_month;
        in_ch.load_day    <= it.load_day;
        in_ch.load_hour   <= it.load_hour;
        in_ch.load_minute <= it.load_minute;
        in_ch.load_second <= it.load_second;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int quota, input bit with_hold, input bit with_pause);
        int done;
        int len;
        logic [ACTION_W-1:0] dir;
        logic [ACTION_W-1:0] back;
        done = 0;
        while (done < quota)
        begin
            if (with_hold && done >= 40)
            begin
                // keep offering while results back up behind the hold
                rx_hold_left = RX_HOLD;
                with_hold = 1'b0;
            end
            if (with_pause && done >= quota / 2)
            begin
                drain();
                with_pause = 1'b0;
            end
            if ($urandom_range(99) < 15)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_beat(noise_item());
                done += len;
            end
            else
            begin
                dir  = $urandom_range(1) ? ACT_INC : ACT_DEC;
                back = (dir == ACT_INC) ? ACT_DEC : ACT_INC;
                len  = $urandom_range(1, 10);
                send_beat(edge_date());
                repeat (len) send_beat(step_item(($urandom_range(99) < 80) ? dir : back));
                done += len + 1;
            end
        end
    endtask

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_LOAD;
        in_ch.load_year   = '0;
        in_ch.load_month  = '0;
        in_ch.load_day    = '0;
        in_ch.load_hour   = '0;
        in_ch.load_minute = '0;
        in_ch.load_second = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state, then borrow and carry across the year 2000 boundary
        send_beat(step_item(ACT_HOLD));
        send_beat(step_item(ACT_DEC));
        send_beat(step_item(ACT_INC));
        // year offset wraps both ways
        send_beat(mk_item(ACT_LOAD, 2127, 12, 31, 23, 59, 59));
        send_beat(step_item(ACT_INC));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 1872, 1, 1, 0, 0, 0));
        send_beat(step_item(ACT_DEC));
        // leap rules: 2000 is leap, 2100 and 1900 are not, 2024 is
        send_beat(mk_item(ACT_LOAD, 2000, 2, 28, 23, 59, 59));
        send_beat(step_item(ACT_INC));
        send_beat(mk_item(ACT_LOAD, 2100, 2, 28, 23, 59, 59));
        send_beat(step_item(ACT_INC));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 1900, 3, 1, 0, 0, 0));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 2024, 3, 1, 0, 0, 0));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 2099, 12, 31, 23, 59, 59));
        send_beat(step_item(ACT_INC));
        // out-of-range loads behave as plain registers
        send_beat(mk_item(ACT_LOAD, 0, 0, 0, 0, 0, 0));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 4095, 15, 31, 31, 63, 63));
        send_beat(step_item(ACT_INC));
        send_beat(mk_item(ACT_LOAD, 2001, 0, 1, 0, 0, 0));
        send_beat(step_item(ACT_DEC));
        send_beat(mk_item(ACT_LOAD, 2001, 13, 31, 23, 59, 59));
        send_beat(step_item(ACT_INC));
        send_beat(mk_item(ACT_LOAD, 2023, 2, 30, 23, 59, 59));
        send_beat(step_item(ACT_INC));

        write_delay(24'hFFFFFF);
        run_random(PHASE_BEATS, 1'b1, 1'b0);

        write_delay(DELAY_W'($urandom_range(1, 24'hFFFFFE)));
        run_random(PHASE_BEATS, 1'b0, 1'b0);

        // back-to-back stretch on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_delay('0);
        run_random(PHASE_BEATS, 1'b0, 1'b0);
        tx_idle_pct = 34;
        rx_idle_pct = 34;

        write_delay(DELAY_W'(24'h800000 | $urandom_range(24'h7FFFFF)));
        run_random(PHASE_BEATS, 1'b0, 1'b1);

        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
